// ===== rtl/tdma_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_pkg
// shared types, constants and helpers of the tdma slot table
// ----------------------------------------------------------------------------
package tdma_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LIM_W        = 5;
    localparam int BEACON_BYTES = 11;
    localparam int K_W          = 4;

    localparam logic [31:0] DEF_INTERVAL = 32'd100000;
    localparam logic [15:0] DEF_SLOT     = 16'd10000;
    localparam logic [15:0] DEF_GUARD    = 16'd0;
    localparam logic [4:0]  DEF_LIMIT    = 5'd16;
    localparam logic [7:0]  DEF_VERSION  = 8'd1;

    typedef enum logic [1:0] {
        OP_REG    = 2'd0,
        OP_WIN    = 2'd1,
        OP_BEACON = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_ID  = 3'd1,
        ST_FULL    = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_CAP     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_INTERVAL = 3'd0,
        REG_SLOT     = 3'd1,
        REG_GUARD    = 3'd2,
        REG_LIMIT    = 3'd3,
        REG_VERSION  = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_BASE,
        S_WS,
        S_TMP,
        S_WE,
        S_RESP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [15:0]      node;
        logic [LIM_W-1:0] limit;
    } t_scan_req;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_ok;
        logic [IDX_W-1:0] free_idx;
    } t_scan_res;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [15:0]      node;
    } t_tbl_wr;

    // clamp the node limit into 1..TABLE_DEPTH
    function automatic logic [LIM_W-1:0] eff_limit(input logic [LIM_W-1:0] lim);
        logic [LIM_W-1:0] n;
        n = lim;
        if (lim == '0) begin
            n = LIM_W'(1);
        end else if (int'(lim) > TABLE_DEPTH) begin
            n = LIM_W'(TABLE_DEPTH);
        end
        return n;
    endfunction

endpackage

// ===== rtl/tdma_slot_table_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_slot_table_top
// tdma slot table: node registration, guarded window query, beacon payload
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 contents
//  s_axis    in         tvalid / tready           op, node_ident, time_us, capacity
//  m_axis    out        tvalid / tready / tlast   status, slot, window, payload byte
//  apb       in         psel / penable / pready   five config registers at 4*i
//
//  one word is taken only in idle; the lookup walks the table one entry per
//  cycle, up to the limit entries, and stops early on a hit
//  a window query adds one multiply and four passes through the shared adder
//  a beacon word then sends eleven result words, one per cycle without stall
//  reset is synchronous, clears the table valid bits and restores config
//  a stalled m_axis holds its word; the sequencer waits until the slot frees
//
module tdma_slot_table_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // op [1:0], node_ident [17:2], time_us [81:18], buffer_capacity [97:82]
    input  logic [103:0]  s_axis_tdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // status [2:0], slot_number [10:3], window_start [74:11],
    // window_end [138:75], payload_byte [146:139]
    output logic [151:0]  m_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic          m_axis_tlast,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IW = tdma_pkg::IDX_W;
    localparam int PW = IW + 16;
    localparam logic [tdma_pkg::K_W-1:0] K_LAST = tdma_pkg::K_W'(tdma_pkg::BEACON_BYTES - 1);

    // config registers
    logic [31:0]                 r_interval;
    logic [15:0]                 r_slot_len;
    logic [15:0]                 r_guard;
    logic [tdma_pkg::LIM_W-1:0]  r_limit;
    logic [7:0]                  r_version;

    logic [31:0]                 eff_int;
    logic [15:0]                 eff_slot;
    logic [tdma_pkg::LIM_W-1:0]  eff_lim;
    logic                        cfg_wr;

    assign eff_int  = (r_interval == '0) ? tdma_pkg::DEF_INTERVAL : r_interval;
    assign eff_slot = (r_slot_len == '0) ? tdma_pkg::DEF_SLOT : r_slot_len;
    assign eff_lim  = tdma_pkg::eff_limit(r_limit);
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= tdma_pkg::DEF_INTERVAL;
            r_slot_len <= tdma_pkg::DEF_SLOT;
            r_guard    <= tdma_pkg::DEF_GUARD;
            r_limit    <= tdma_pkg::DEF_LIMIT;
            r_version  <= tdma_pkg::DEF_VERSION;
        end else if (cfg_wr) begin
            unique case (tdma_pkg::t_reg_idx'(paddr[4:2]))
                tdma_pkg::REG_INTERVAL: r_interval <= pwdata;
                tdma_pkg::REG_SLOT:     r_slot_len <= pwdata[15:0];
                tdma_pkg::REG_GUARD:    r_guard    <= pwdata[15:0];
                tdma_pkg::REG_LIMIT:    r_limit    <= pwdata[tdma_pkg::LIM_W-1:0];
                tdma_pkg::REG_VERSION:  r_version  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // register read mux
    always_comb begin
        unique case (tdma_pkg::t_reg_idx'(paddr[4:2]))
            tdma_pkg::REG_INTERVAL: prdata = r_interval;
            tdma_pkg::REG_SLOT:     prdata = {16'd0, r_slot_len};
            tdma_pkg::REG_GUARD:    prdata = {16'd0, r_guard};
            tdma_pkg::REG_LIMIT:    prdata = 32'(r_limit);
            tdma_pkg::REG_VERSION:  prdata = {24'd0, r_version};
            default:                prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    tdma_pkg::t_state        r_state, n_state;
    tdma_pkg::t_op           r_op, n_op;
    logic [15:0]             r_id, n_id;
    logic [63:0]             r_time, n_time;
    tdma_pkg::t_status       r_st, n_st;
    logic [IW-1:0]           r_slot, n_slot;
    logic [PW-1:0]           r_prod, n_prod;
    logic [63:0]             r_base, n_base;
    logic [63:0]             r_ws, n_ws;
    logic [63:0]             r_we, n_we;
    logic [tdma_pkg::K_W-1:0] r_k, n_k;

    // output word register
    logic                    r_o_valid, n_o_valid;
    tdma_pkg::t_status       r_o_status, n_o_status;
    logic [7:0]              r_o_slot, n_o_slot;
    logic [63:0]             r_o_ws, n_o_ws;
    logic [63:0]             r_o_we, n_o_we;
    logic [7:0]              r_o_pb, n_o_pb;
    logic                    r_o_last, n_o_last;

    logic                    out_free;
    logic                    collapse;
    logic [7:0]              pay_byte;

    // shared unit and table
    logic [63:0]             alu_a, alu_b, alu_sum;
    logic                    alu_sub;
    tdma_pkg::t_scan_req     scan_req;
    tdma_pkg::t_scan_res     scan_res;
    tdma_pkg::t_tbl_wr       tbl_wr;

    tdma_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    tdma_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .i_wr    (tbl_wr),
        .o_res   (scan_res)
    );

    assign s_axis_tready = (r_state == tdma_pkg::S_IDLE);
    assign out_free      = !r_o_valid || m_axis_tready;
    // window collapses when the slot is no longer than twice the guard (16-bit wrap)
    assign collapse      = (eff_slot <= {r_guard[14:0], 1'b0});

    // beacon payload, little endian fields
    always_comb begin
        case (r_k)
            4'd0:    pay_byte = r_version;
            4'd1:    pay_byte = 8'(r_slot);
            4'd2:    pay_byte = eff_int[7:0];
            4'd3:    pay_byte = eff_int[15:8];
            4'd4:    pay_byte = eff_int[23:16];
            4'd5:    pay_byte = eff_int[31:24];
            4'd6:    pay_byte = eff_slot[7:0];
            4'd7:    pay_byte = eff_slot[15:8];
            4'd8:    pay_byte = r_guard[7:0];
            4'd9:    pay_byte = r_guard[15:8];
            4'd10:   pay_byte = 8'(eff_lim);
            default: pay_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tdma_pkg::S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_time     <= n_time;
        r_st       <= n_st;
        r_slot     <= n_slot;
        r_prod     <= n_prod;
        r_base     <= n_base;
        r_ws       <= n_ws;
        r_we       <= n_we;
        r_k        <= n_k;
        r_o_status <= n_o_status;
        r_o_slot   <= n_o_slot;
        r_o_ws     <= n_o_ws;
        r_o_we     <= n_o_we;
        r_o_pb     <= n_o_pb;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_id       = r_id;
        n_time     = r_time;
        n_st       = r_st;
        n_slot     = r_slot;
        n_prod     = r_prod;
        n_base     = r_base;
        n_ws       = r_ws;
        n_we       = r_we;
        n_k        = r_k;
        n_o_valid  = r_o_valid && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_slot   = r_o_slot;
        n_o_ws     = r_o_ws;
        n_o_we     = r_o_we;
        n_o_pb     = r_o_pb;
        n_o_last   = r_o_last;
        alu_a      = r_base;
        alu_b      = '0;
        alu_sub    = 1'b0;
        scan_req.start = 1'b0;
        scan_req.node  = s_axis_tdata[17:2];
        scan_req.limit = eff_lim;
        tbl_wr.we      = 1'b0;
        tbl_wr.idx     = scan_res.free_idx;
        tbl_wr.node    = r_id;

        unique case (r_state)
            tdma_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op   = tdma_pkg::t_op'(s_axis_tdata[1:0]);
                    n_id   = s_axis_tdata[17:2];
                    n_time = s_axis_tdata[81:18];
                    n_st   = tdma_pkg::ST_OK;
                    n_slot = '0;
                    n_ws   = '0;
                    n_we   = '0;
                    n_k    = '0;
                    unique case (tdma_pkg::t_op'(s_axis_tdata[1:0]))
                        tdma_pkg::OP_REG: begin
                            if (s_axis_tdata[17:2] == 16'd0) begin
                                n_st    = tdma_pkg::ST_BAD_ID;
                                n_state = tdma_pkg::S_RESP;
                            end else begin
                                scan_req.start = 1'b1;
                                n_state        = tdma_pkg::S_SCAN;
                            end
                        end
                        tdma_pkg::OP_WIN: begin
                            scan_req.start = 1'b1;
                            n_state        = tdma_pkg::S_SCAN;
                        end
                        tdma_pkg::OP_BEACON: begin
                            // capacity is checked before the lookup
                            if (int'(s_axis_tdata[97:82]) < tdma_pkg::BEACON_BYTES) begin
                                n_st    = tdma_pkg::ST_CAP;
                                n_state = tdma_pkg::S_RESP;
                            end else begin
                                scan_req.start = 1'b1;
                                n_state        = tdma_pkg::S_SCAN;
                            end
                        end
                        default: n_state = tdma_pkg::S_IDLE;
                    endcase
                end
            end
            tdma_pkg::S_SCAN: begin
                if (scan_res.done) begin
                    unique case (r_op)
                        tdma_pkg::OP_REG: begin
                            n_state = tdma_pkg::S_RESP;
                            if (scan_res.hit) begin
                                n_slot = scan_res.hit_idx;
                            end else if (scan_res.free_ok) begin
                                tbl_wr.we = 1'b1;
                                n_slot    = scan_res.free_idx;
                            end else begin
                                n_st = tdma_pkg::ST_FULL;
                            end
                        end
                        tdma_pkg::OP_WIN: begin
                            if (scan_res.hit) begin
                                n_slot  = scan_res.hit_idx;
                                n_state = tdma_pkg::S_MUL;
                            end else begin
                                n_st    = tdma_pkg::ST_UNKNOWN;
                                n_state = tdma_pkg::S_RESP;
                            end
                        end
                        default: begin
                            if (scan_res.hit) begin
                                n_slot  = scan_res.hit_idx;
                                n_state = tdma_pkg::S_EMIT;
                            end else begin
                                n_st    = tdma_pkg::ST_UNKNOWN;
                                n_state = tdma_pkg::S_RESP;
                            end
                        end
                    endcase
                end
            end
            tdma_pkg::S_MUL: begin
                n_prod  = PW'(r_slot) * PW'(eff_slot);
                n_state = tdma_pkg::S_BASE;
            end
            tdma_pkg::S_BASE: begin
                alu_a   = r_time;
                alu_b   = 64'(r_prod);
                n_base  = alu_sum;
                n_state = tdma_pkg::S_WS;
            end
            tdma_pkg::S_WS: begin
                alu_b   = 64'(r_guard);
                n_ws    = alu_sum;
                n_state = tdma_pkg::S_TMP;
            end
            tdma_pkg::S_TMP: begin
                alu_b   = 64'(eff_slot);
                n_we    = alu_sum;
                n_state = tdma_pkg::S_WE;
            end
            tdma_pkg::S_WE: begin
                alu_a   = r_we;
                alu_b   = 64'(r_guard);
                alu_sub = 1'b1;
                n_we    = collapse ? r_ws : alu_sum;
                n_state = tdma_pkg::S_RESP;
            end
            tdma_pkg::S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_st;
                    n_o_slot   = 8'(r_slot);
                    n_o_ws     = r_ws;
                    n_o_we     = r_we;
                    n_o_pb     = 8'd0;
                    n_o_last   = 1'b1;
                    n_state    = tdma_pkg::S_IDLE;
                end
            end
            tdma_pkg::S_EMIT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = tdma_pkg::ST_OK;
                    n_o_slot   = 8'(r_slot);
                    n_o_ws     = '0;
                    n_o_we     = '0;
                    n_o_pb     = pay_byte;
                    n_o_last   = (r_k == K_LAST);
                    if (r_k == K_LAST) begin
                        n_state = tdma_pkg::S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = tdma_pkg::S_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tlast  = r_o_last;
    assign m_axis_tdata  = {5'd0, r_o_pb, r_o_we, r_o_ws, r_o_slot, r_o_status};

    // a scan reports only while the sequencer waits for it
    a_scan_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_res.done |-> (r_state == tdma_pkg::S_SCAN))
        else $error("scan result outside scan state");

    // table entries are written only on a registration miss
    a_write_on_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_wr.we |-> (r_state == tdma_pkg::S_SCAN && r_op == tdma_pkg::OP_REG
                       && !scan_res.hit && scan_res.free_ok))
        else $error("table write outside registration");

    // a hit always lies below the active limit
    a_hit_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (scan_res.done && scan_res.hit) |->
            ((tdma_pkg::LIM_W + 1)'(scan_res.hit_idx) < (tdma_pkg::LIM_W + 1)'(eff_lim)))
        else $error("hit beyond active limit");

    // loading the final payload byte shows a last word next cycle
    a_payload_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tdma_pkg::S_EMIT && out_free && r_k == K_LAST) |=>
            (m_axis_tvalid && m_axis_tlast && r_state != tdma_pkg::S_EMIT))
        else $error("payload did not end with last word");

endmodule

// ===== rtl/tdma_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_table
// node table with a one-entry-per-cycle lookup and free-entry scan
// ----------------------------------------------------------------------------
module tdma_table (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdma_pkg::t_scan_req  i_req,
    input  tdma_pkg::t_tbl_wr    i_wr,
    output tdma_pkg::t_scan_res  o_res
);

    logic [tdma_pkg::TABLE_DEPTH-1:0] r_valid;
    logic [15:0]                      r_node [tdma_pkg::TABLE_DEPTH];

    logic                           r_busy;
    logic [tdma_pkg::IDX_W-1:0]     r_idx;
    logic [15:0]                    r_id;
    logic [tdma_pkg::LIM_W-1:0]     r_lim;
    tdma_pkg::t_scan_res            r_res;

    logic                           cur_hit;
    logic                           cur_free;
    logic                           at_end;

    assign cur_hit  = r_valid[r_idx] && (r_node[r_idx] == r_id);
    assign cur_free = !r_valid[r_idx];
    assign at_end   = (tdma_pkg::LIM_W'(r_idx) == (r_lim - tdma_pkg::LIM_W'(1)));

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_node[i_wr.idx] <= i_wr.node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_busy    <= 1'b0;
            r_res     <= '0;
        end else begin
            r_res.done <= 1'b0;
            if (i_wr.we) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_req.start) begin
                r_busy        <= 1'b1;
                r_idx         <= '0;
                r_id          <= i_req.node;
                r_lim         <= i_req.limit;
                r_res.free_ok <= 1'b0;
                r_res.hit     <= 1'b0;
            end else if (r_busy) begin
                // keep the lowest free entry seen so far
                if (cur_free && !r_res.free_ok) begin
                    r_res.free_ok  <= 1'b1;
                    r_res.free_idx <= r_idx;
                end
                if (cur_hit || at_end) begin
                    r_busy        <= 1'b0;
                    r_res.done    <= 1'b1;
                    r_res.hit     <= cur_hit;
                    r_res.hit_idx <= r_idx;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== rtl/tdma_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_alu
// shared 64-bit add / subtract unit for the window arithmetic
// ----------------------------------------------------------------------------
module tdma_alu (
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic        i_sub,
    output logic [63:0] o_sum
);

    logic [63:0] b_eff;

    assign b_eff = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_eff + 64'(i_sub);

endmodule
